// File: rtl/core/rit_pkg.sv
`default_nettype none

package rit_pkg;

   // Table geometry.
   localparam int RIT_ENTRIES = 64;

   // Field widths of the request and response items.
   localparam int CMD_W    = 3;
   localparam int KEY_W    = 64;
   localparam int ATTRS_W  = 64;
   localparam int LINKS_W  = 32;
   localparam int REFS_W   = 32;
   localparam int STATUS_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RETAIN  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESOLVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FORGET  = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   // One table slot as it is stored in the slot memory.
   typedef struct packed {
      logic               valid;
      logic               detached;
      logic [REFS_W-1:0]  refs;
      logic [KEY_W-1:0]   key;
      logic [ATTRS_W-1:0] attrs;
   } slot_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_APPLY = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/core/rit_req_if.sv
`default_nettype none

interface rit_req_if
   import rit_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [KEY_W-1:0]   inode_id;
   logic [ATTRS_W-1:0] inode_attrs;
   logic [LINKS_W-1:0] link_count;
   logic [REFS_W-1:0]  release_count;

   modport source (
      output valid, command, inode_id, inode_attrs, link_count, release_count,
      input  ready
   );

   modport sink (
      input  valid, command, inode_id, inode_attrs, link_count, release_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/rit_rsp_if.sv
`default_nettype none

interface rit_rsp_if
   import rit_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ATTRS_W-1:0]  out_attrs;
   logic [LINKS_W-1:0]  out_link_count;

   modport source (
      output valid, status, out_attrs, out_link_count,
      input  ready
   );

   modport sink (
      input  valid, status, out_attrs, out_link_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/refcounted_inode_table.sv
// Reference-counted inode table with one request channel and one response channel.
// Each request carries a command (clear, retain, refresh, resolve, forget), a 64-bit
// inode id and the payload; every request produces exactly one response with a status
// and, for a successful resolve, the stored attribute word.
// A request is scanned against the slot memory one slot per cycle through a single
// key comparator; a request whose key hits early finishes sooner than one that
// searches the whole table. Clear rewrites every slot, one per cycle. One request is
// in work at a time; the next one is accepted in the cycle after the previous
// response has been registered. After reset the block runs a clearing pass over every
// slot of the slot memory, during which req_bus.ready stays low.
// The response sits in an output register: while the receiver stalls, the held
// response stays stable and a new request can still be accepted and scanned; it then
// waits in its final step until the output register is free.
// The link count carried with a request is never observable in any response (a
// resolve always returns a zero link count), so it is not stored.

`default_nettype none

module refcounted_inode_table
   import rit_pkg::*;
#(
   parameter int ENTRIES = RIT_ENTRIES
) (
   input  wire       clock,
   input  wire       reset,
   rit_req_if.sink   req_bus,
   rit_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // Sequencer and captured request.
   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [ATTRS_W-1:0] attrs_ff;
   logic [REFS_W-1:0]  rel_ff;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic [IDX_W-1:0]   sweep_idx_ff, sweep_idx_in;

   // Scan pipeline: one read issued per cycle, checked in the cycle after it.
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               issue_ff, issue_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   slot_type           rd_data_ff;

   // Scan results.
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   slot_type           hit_data_ff, hit_data_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ATTRS_W-1:0]  rsp_attrs_ff, rsp_attrs_in;

   // Slot memory ports.
   slot_type           slot_mem [ENTRIES];
   logic               mem_rd_en;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wr_addr;
   slot_type           mem_wr_data;

   logic               req_fire;
   logic               apply_go;
   logic               key_match;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // The final step may only complete when the output register is free or draining.
   assign apply_go  = !rsp_valid_ff || rsp_bus.ready;
   assign key_match = rd_data_ff.valid && (rd_data_ff.key == key_ff);

   assign mem_rd_en = (state_ff == ST_SCAN) && issue_ff;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.out_attrs      = rsp_attrs_ff;
   assign rsp_bus.out_link_count = '0;

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= slot_mem[addr_ff];
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      sweep_idx_in  = sweep_idx_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      chk_vld_in    = (state_ff == ST_SCAN) && issue_ff;
      chk_idx_in    = addr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_attrs_in  = rsp_attrs_ff;
      mem_we        = 1'b0;
      mem_wr_addr   = sweep_idx_ff;
      mem_wr_data   = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            // Invalidate one slot per cycle.
            mem_we       = 1'b1;
            mem_wr_addr  = sweep_idx_ff;
            mem_wr_data  = '0;
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == LAST_IDX) begin
               sweep_idx_in = '0;
               state_in     = sweep_rsp_ff ? ST_APPLY : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               addr_in       = '0;
               issue_in      = 1'b1;
               sweep_idx_in  = '0;
               sweep_rsp_in  = (req_bus.command == CMD_CLEAR);
               state_in      = (req_bus.command == CMD_CLEAR) ? ST_SWEEP : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (chk_vld_ff) begin
               if (key_match) begin
                  // Lowest matching slot wins; stop scanning.
                  hit_in      = 1'b1;
                  hit_idx_in  = chk_idx_ff;
                  hit_data_in = rd_data_ff;
                  issue_in    = 1'b0;
                  state_in    = ST_APPLY;
               end else begin
                  if (!rd_data_ff.valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     state_in = ST_APPLY;
                  end
               end
            end
         end

         ST_APPLY: begin
            if (apply_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_IGNORED;
               rsp_attrs_in  = '0;
               mem_wr_addr   = hit_idx_ff;
               mem_wr_data   = hit_data_ff;
               state_in      = ST_IDLE;
               case (cmd_ff)
                  CMD_CLEAR: begin
                     rsp_status_in = STATUS_DONE;
                  end
                  CMD_RETAIN: begin
                     if (!hit_ff) begin
                        if (!free_found_ff) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           mem_we               = 1'b1;
                           mem_wr_addr          = free_idx_ff;
                           mem_wr_data.valid    = 1'b1;
                           mem_wr_data.detached = 1'b0;
                           mem_wr_data.refs     = REFS_W'(1);
                           mem_wr_data.key      = key_ff;
                           mem_wr_data.attrs    = attrs_ff;
                           rsp_status_in        = STATUS_DONE;
                        end
                     end else if (hit_data_ff.refs == '1) begin
                        rsp_status_in = STATUS_OVERFLOW;
                     end else begin
                        mem_we           = 1'b1;
                        mem_wr_data.refs = hit_data_ff.refs + 1'b1;
                        if (!hit_data_ff.detached) begin
                           mem_wr_data.attrs = attrs_ff;
                        end
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  CMD_REFRESH: begin
                     if (hit_ff && !hit_data_ff.detached) begin
                        mem_we            = 1'b1;
                        mem_wr_data.attrs = attrs_ff;
                        rsp_status_in     = STATUS_DONE;
                     end
                  end
                  CMD_RESOLVE: begin
                     if (hit_ff && (hit_data_ff.refs != '0)) begin
                        mem_we               = 1'b1;
                        mem_wr_data.detached = 1'b1;
                        rsp_attrs_in         = hit_data_ff.attrs;
                        rsp_status_in        = STATUS_DONE;
                     end
                  end
                  CMD_FORGET: begin
                     if ((rel_ff != '0) && hit_ff) begin
                        mem_we = 1'b1;
                        if (rel_ff >= hit_data_ff.refs) begin
                           mem_wr_data.valid = 1'b0;
                        end else begin
                           mem_wr_data.refs = hit_data_ff.refs - rel_ff;
                        end
                        rsp_status_in = STATUS_DONE;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_IGNORED;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_rsp_ff  <= 1'b0;
         sweep_idx_ff  <= '0;
         issue_ff      <= 1'b0;
         chk_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_rsp_ff  <= sweep_rsp_in;
         sweep_idx_ff  <= sweep_idx_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      chk_idx_ff    <= chk_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_attrs_ff  <= rsp_attrs_in;
      if (req_fire) begin
         cmd_ff   <= req_bus.command;
         key_ff   <= req_bus.inode_id;
         attrs_ff <= req_bus.inode_attrs;
         rel_ff   <= req_bus.release_count;
      end
   end

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

// The testbench drives one request stream into the inode table and checks every
// response it returns. It keeps its own copy of the table and updates that copy at
// the clock edge where a request is accepted. The expected response is then queued
// and compared with the next response that the receiver takes.
//
// Two conditions are never reached. Count overflow would need more than four
// billion retains of one key. A resolve of an entry with no references cannot
// happen, because a forget frees the entry as soon as its count would reach zero.
// The checker still models both cases in full.

module tb;
   import rit_pkg::*;

   // Command codes that the block does not define. Each one must be ignored.
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic [KEY_W-1:0]   KEY_MAX   = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0]   KEY_EDGE  = 64'h8000_0000_0000_0001;
   localparam logic [ATTRS_W-1:0] ATTRS_MAX = {ATTRS_W{1'b1}};
   localparam logic [ATTRS_W-1:0] ATTRS_A   = 64'h0123_4567_89AB_CDEF;
   localparam logic [ATTRS_W-1:0] ATTRS_B   = 64'hA5A5_5A5A_F00D_C0DE;
   localparam logic [REFS_W-1:0]  COUNT_MAX = {REFS_W{1'b1}};

   localparam int KEY_POOL_N   = 80;  // more keys than slots, so the table fills up
   localparam int FILL_N       = 66;  // two retains past a full table
   localparam int MIXED_N      = 64;
   localparam int STALL_LIMIT  = 3000;
   localparam int SETTLE_TIME  = 80;  // one full-table scan, plus margin
   localparam int DIRECTED_N   = 26;

   // One request, together with the response that is typed in where it is obvious.
   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [KEY_W-1:0]    inode_id;
      logic [ATTRS_W-1:0]  attrs;
      logic [LINKS_W-1:0]  links;
      logic [REFS_W-1:0]   drop;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic [ATTRS_W-1:0]  out_attrs;
   } request_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ATTRS_W-1:0]  attrs;
      logic [LINKS_W-1:0]  links;
   } inode_rsp_type;

   // The directed table walks the table through its special cases. Rows with
   // typed == 0 are checked against the table copy held by the testbench.
   request_row_type directed_rows [DIRECTED_N] = '{
      // After reset nothing is present.
      '{CMD_RESOLVE, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_FORGET, KEY_MAX, 64'd0, 32'd0, 32'd1, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_REFRESH, 64'd0, ATTRS_MAX, COUNT_MAX, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      // Insert both extreme keys, with extreme payloads.
      '{CMD_RETAIN, 64'd0, ATTRS_MAX, COUNT_MAX, 32'd0, 1'b1, STATUS_DONE, 64'd0},
      '{CMD_RETAIN, KEY_MAX, 64'd0, 32'd0, COUNT_MAX, 1'b1, STATUS_DONE, 64'd0},
      // A second reference replaces the payload while the entry is live.
      '{CMD_RETAIN, 64'd0, ATTRS_A, 32'h1234_5678, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_DONE, ATTRS_A},
      // Once detached, refresh is refused and retain keeps the old payload.
      '{CMD_REFRESH, 64'd0, ATTRS_B, 32'd1, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_RETAIN, 64'd0, ATTRS_B, 32'd7, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_DONE, ATTRS_A},
      // A forget of zero references does nothing. A partial forget keeps the entry.
      '{CMD_FORGET, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_FORGET, 64'd0, 64'd0, 32'd0, 32'd2, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      // Forgetting more references than the entry holds frees it.
      '{CMD_FORGET, 64'd0, 64'd0, 32'd0, COUNT_MAX, 1'b1, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_REFRESH, KEY_MAX, ATTRS_B, COUNT_MAX, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, KEY_MAX, 64'd0, 32'd0, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      // Codes outside the command set are ignored.
      '{CMD_SPARE_5, KEY_MAX, ATTRS_MAX, COUNT_MAX, COUNT_MAX, 1'b1, STATUS_IGNORED,
        64'd0},
      '{CMD_SPARE_6, 64'd0, 64'd0, 32'd0, 32'd1, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_SPARE_7, KEY_MAX, ATTRS_A, 32'd5, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      // Clear drops every entry. The first slot is then reused.
      '{CMD_CLEAR, KEY_MAX, ATTRS_MAX, COUNT_MAX, COUNT_MAX, 1'b1, STATUS_DONE, 64'd0},
      '{CMD_RESOLVE, KEY_MAX, 64'd0, 32'd0, 32'd0, 1'b1, STATUS_IGNORED, 64'd0},
      '{CMD_RETAIN, KEY_EDGE, ATTRS_MAX, 32'd0, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_RETAIN, KEY_EDGE, ATTRS_B, 32'd9, 32'd0, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_FORGET, KEY_EDGE, 64'd0, 32'd0, 32'd1, 1'b0, STATUS_DONE, 64'd0},
      '{CMD_FORGET, KEY_EDGE, 64'd0, 32'd0, 32'd3, 1'b1, STATUS_DONE, 64'd0}
   };

   logic clock = 1'b0;
   logic reset;

   rit_req_if req_bus ();
   rit_rsp_if rsp_bus ();

   refcounted_inode_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The testbench's own copy of the table.
   logic [RIT_ENTRIES-1:0] entry_used;
   logic [KEY_W-1:0]       entry_id       [RIT_ENTRIES];
   logic [REFS_W-1:0]      entry_refs     [RIT_ENTRIES];
   logic                   entry_detached [RIT_ENTRIES];
   logic [ATTRS_W-1:0]     entry_attrs    [RIT_ENTRIES];

   inode_rsp_type   awaited_rsps [$];
   request_row_type current_row;
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];

   int send_idle_pct;
   int recv_idle_pct;
   int failures     = 0;
   int quiet_cycles = 0;

   // Applies one command to the table copy and returns the response it must give.
   // The lookup takes the lowest-numbered matching entry. An insertion takes the
   // lowest free entry.
   function automatic inode_rsp_type predict_inode_op(input logic [CMD_W-1:0] command,
                                                      input logic [KEY_W-1:0] inode_id,
                                                      input logic [ATTRS_W-1:0] attrs,
                                                      input logic [REFS_W-1:0] drop);
      inode_rsp_type res;
      int hit;
      int vacant;
      res = '{STATUS_IGNORED, 64'd0, 32'd0};
      hit = -1;
      vacant = -1;
      for (int i = RIT_ENTRIES - 1; i >= 0; i--) begin
         if (entry_used[i] && entry_id[i] == inode_id) begin
            hit = i;
         end
         if (!entry_used[i]) begin
            vacant = i;
         end
      end
      case (command)
         CMD_CLEAR: begin
            entry_used = '0;
            res.status = STATUS_DONE;
         end
         CMD_RETAIN: begin
            if (hit < 0) begin
               if (vacant < 0) begin
                  res.status = STATUS_FULL;
               end else begin
                  entry_used[vacant]     = 1'b1;
                  entry_id[vacant]       = inode_id;
                  entry_refs[vacant]     = 32'd1;
                  entry_detached[vacant] = 1'b0;
                  entry_attrs[vacant]    = attrs;
                  res.status = STATUS_DONE;
               end
            end else if (entry_refs[hit] == COUNT_MAX) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               entry_refs[hit] = entry_refs[hit] + 32'd1;
               if (!entry_detached[hit]) begin
                  entry_attrs[hit] = attrs;
               end
               res.status = STATUS_DONE;
            end
         end
         CMD_REFRESH: begin
            if (hit >= 0 && !entry_detached[hit]) begin
               entry_attrs[hit] = attrs;
               res.status = STATUS_DONE;
            end
         end
         CMD_RESOLVE: begin
            if (hit >= 0 && entry_refs[hit] != 32'd0) begin
               entry_detached[hit] = 1'b1;
               res.attrs  = entry_attrs[hit];
               res.status = STATUS_DONE;
            end
         end
         CMD_FORGET: begin
            if (drop != 32'd0 && hit >= 0) begin
               if (drop >= entry_refs[hit]) begin
                  entry_used[hit] = 1'b0;
               end else begin
                  entry_refs[hit] = entry_refs[hit] - drop;
               end
               res.status = STATUS_DONE;
            end
         end
         default: begin
            // The spare codes leave the table untouched.
         end
      endcase
      return res;
   endfunction

   // The checker runs at the rising edge. A response leaves first. Then a request
   // that is accepted in the same cycle is added to the table copy.
   always @(posedge clock) begin
      inode_rsp_type want;
      inode_rsp_type modeled;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
               $display("%0t: response with no request outstanding: status %0d attrs %h",
                        $time, rsp_bus.status, rsp_bus.out_attrs);
               failures++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_bus.status);
                  failures++;
               end
               if (rsp_bus.out_attrs !== want.attrs) begin
                  $display("%0t: out_attrs expected %h, got %h",
                           $time, want.attrs, rsp_bus.out_attrs);
                  failures++;
               end
               if (rsp_bus.out_link_count !== want.links) begin
                  $display("%0t: out_link_count expected %0d, got %0d",
                           $time, want.links, rsp_bus.out_link_count);
                  failures++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            modeled = predict_inode_op(req_bus.command, req_bus.inode_id,
                                       req_bus.inode_attrs, req_bus.release_count);
            if (current_row.typed) begin
               awaited_rsps.push_back(inode_rsp_type'{current_row.status,
                                                      current_row.out_attrs, 32'd0});
            end else begin
               awaited_rsps.push_back(modeled);
            end
         end
      end
   end

   // The receiver takes responses, with random stalls in proportion recv_idle_pct.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // The watchdog counts cycles with no request and no response accepted. The
   // clearing pass after reset and the longest table scan both fit well under
   // the limit.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Presents one request, starting at a falling edge, and returns at the falling
   // edge after it is accepted. Before the request the sender may stay idle for
   // some cycles.
   task automatic issue_request(input request_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= r.command;
      req_bus.inode_id      <= r.inode_id;
      req_bus.inode_attrs   <= r.attrs;
      req_bus.link_count    <= r.links;
      req_bus.release_count <= r.drop;
      current_row           <= r;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stops sending until every response in flight has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (awaited_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      request_row_type r;
      int pick;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_CLEAR;
      req_bus.inode_id      = '0;
      req_bus.inode_attrs   = '0;
      req_bus.link_count    = '0;
      req_bus.release_count = '0;
      rsp_bus.ready         = 1'b0;
      current_row           = '0;
      entry_used            = '0;
      send_idle_pct         = 17;
      recv_idle_pct         = 77;

      // The pool keeps both extreme keys. It also holds more keys than the table
      // has slots, so random retains run into a full table.
      key_pool[0] = '0;
      key_pool[1] = KEY_MAX;
      for (int k = 2; k < KEY_POOL_N; k++) begin
         key_pool[k] = {$urandom, $urandom};
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[n]) begin
         issue_request(directed_rows[n]);
      end
      drain_responses();

      // Each phase clears the table and fills it past the last slot. It then mixes
      // random commands over the pool keys, so that hits, misses and full-table
      // refusals all occur. The sender and the receiver swap their idle rates
      // between phases, and the last phase runs with no idling at all.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 17 : 0;

         r = '0;
         r.command = CMD_CLEAR;
         issue_request(r);

         for (int k = 0; k < FILL_N; k++) begin
            r.command  = CMD_RETAIN;
            r.inode_id = key_pool[k];
            r.attrs    = {$urandom, $urandom};
            r.links    = $urandom;
            r.drop     = $urandom;
            issue_request(r);
         end

         for (int k = 0; k < MIXED_N; k++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               r.command = CMD_RETAIN;
            end else if (pick < 50) begin
               r.command = CMD_REFRESH;
            end else if (pick < 65) begin
               r.command = CMD_RESOLVE;
            end else if (pick < 92) begin
               r.command = CMD_FORGET;
            end else if (pick < 95) begin
               r.command = CMD_CLEAR;
            end else begin
               case ($urandom_range(2))
                  0:       r.command = CMD_SPARE_5;
                  1:       r.command = CMD_SPARE_6;
                  default: r.command = CMD_SPARE_7;
               endcase
            end
            r.inode_id = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                   : key_pool[$urandom_range(KEY_POOL_N - 1)];
            r.attrs = {$urandom, $urandom};
            r.links = $urandom;
            // Most forgets drop a few references. Some drop none, and some drop a
            // random 32-bit count that frees the entry.
            pick = $urandom_range(99);
            r.drop = (pick < 10) ? 32'd0 : (pick < 25) ? 32'($urandom)
                                                       : 32'($urandom_range(3, 1));
            issue_request(r);
            // Now and then the sender waits until the table has answered everything.
            if ($urandom_range(19) == 0) begin
               drain_responses();
            end
         end
         drain_responses();
      end

      repeat (SETTLE_TIME) @(negedge clock);
      if (failures == 0 && awaited_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: refcounted_inode_table.f
rtl/core/rit_pkg.sv
rtl/core/rit_req_if.sv
rtl/core/rit_rsp_if.sv
rtl/core/refcounted_inode_table.sv
verif/tb.sv
